// ===== hdl/request_retry_table_macros.svh =====
// Assertion macros shared by the request retry table RTL.
`ifndef REQUEST_RETRY_TABLE_MACROS_SVH
`define REQUEST_RETRY_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("request_retry_table: assertion failed");

// Next-cycle implication, checked outside reset.
`define RRT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("request_retry_table: assertion failed");

`endif

// ===== hdl/rrt_pkg.sv =====
// Types and constants of the request retry table.
package rrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] OP_REQUEST  = 2'd0;
	localparam logic [1:0] OP_RESPONSE = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
	localparam logic [2:0] KIND_FULL      = 3'd1;
	localparam logic [2:0] KIND_MATCHED   = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
	localparam logic [2:0] KIND_RESEND    = 3'd4;
	localparam logic [2:0] KIND_EXHAUSTED = 3'd5;

	localparam logic CFG_INITIAL_TIMEOUT = 1'b0;
	localparam logic CFG_RETRY_LIMIT     = 1'b1;

	localparam logic [31:0] INITIAL_TIMEOUT_RST = 32'd30;
	localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd3;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] stamp;
		logic [31:0] timeout;
		logic [3:0]  retries;
	} entry_t;

endpackage

// ===== hdl/request_retry_table.sv =====
// Request retry table: outstanding request tracking with timeout backoff.
//
// Input channel (in_valid/in_ready, op, request_id): op 0 inserts or refreshes
// a request, op 1 removes a matching entry, op 2 advances time one tick and
// scans the table; op 3 is taken and dropped. Result channel (out_valid/
// out_ready, event_kind, event_id, tick_done, last) carries one item per event;
// last marks the final item of an input, tick_done the final item of a scan.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while the block is idle.
// The entry fields live in one synchronous memory read one slot per cycle
// unless a stall holds the scan, so a request or response walks all TABLE_DEPTH
// slots and a tick walks them until it reaches an exhausted entry; the next
// item is taken only after the current one finishes.
// A tick result is held back by one result until the scan knows whether it is last.
// A stalled receiver holds the scan at the next event once both the output
// register and the held result are full. Reset clears the valid bits, time
// and control state and resets config; memory contents are left as they are.
module request_retry_table
	import rrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] request_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [31:0] event_id,
	output logic        tick_done,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	`include "request_retry_table_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

	entry_t mem [TABLE_DEPTH];

	logic [1:0]             state_q;
	logic [1:0]             op_q;
	logic [31:0]            req_id_q;
	logic [31:0]            time_q;
	logic [31:0]            init_timeout_q;
	logic [3:0]             retry_limit_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [SLOT_W-1:0]      rd_addr_q;
	logic                   issue_q;
	logic                   found_q;
	logic [SLOT_W-1:0]      found_slot_q;
	logic                   vld_s1;
	logic [SLOT_W-1:0]      slot_s1;
	entry_t                 ent_s1;
	logic                   pend_valid_q;
	logic [2:0]             pend_kind_q;
	logic [31:0]            pend_id_q;
	logic                   out_valid_q;
	logic [2:0]             out_kind_q;
	logic [31:0]            out_id_q;
	logic                   out_tdone_q;
	logic                   out_last_q;

	logic              in_acc;
	logic              out_free;
	logic              ev_hit;
	logic              ev_exh;
	logic              stall;
	logic              advance;
	logic              rd_en;
	logic [31:0]       age;
	logic [31:0]       timeout_dbl;
	logic              free_found;
	logic [SLOT_W-1:0] free_slot;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;
	logic              valid_set;
	logic              valid_clr;
	logic              out_load;
	logic [2:0]        out_kind_n;
	logic [31:0]       out_id_n;
	logic              out_tdone_n;
	logic              out_last_n;
	logic              pend_load;
	logic              pend_clr;
	logic [2:0]        pend_kind_n;
	logic [1:0]        state_n;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign event_kind = out_kind_q;
	assign event_id   = out_id_q;
	assign tick_done  = out_tdone_q;
	assign last       = out_last_q;
	assign out_free   = !out_valid_q || out_ready;

	// Expiry test and backoff on the slot held in the read register.
	assign age         = time_q - ent_s1.stamp;
	assign timeout_dbl = ent_s1.timeout[31] ? 32'hFFFF_FFFF : {ent_s1.timeout[30:0], 1'b0};
	assign ev_hit      = (state_q == ST_SCAN) && (op_q == OP_TICK) && vld_s1
	                     && valid_q[slot_s1] && (age >= ent_s1.timeout);
	assign ev_exh      = ev_hit && (ent_s1.retries == 4'd0);
	assign stall       = ev_hit && pend_valid_q && !out_free;
	assign advance     = !stall;
	assign rd_en       = (state_q == ST_SCAN) && issue_q && advance && !ev_exh;

	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = slot_s1;
		wr_data     = ent_s1;
		valid_set   = 1'b0;
		valid_clr   = 1'b0;
		out_load    = 1'b0;
		out_kind_n  = pend_kind_q;
		out_id_n    = pend_id_q;
		out_tdone_n = 1'b0;
		out_last_n  = 1'b0;
		pend_load   = 1'b0;
		pend_clr    = 1'b0;
		pend_kind_n = KIND_RESEND;
		state_n     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (op == OP_REQUEST || op == OP_RESPONSE || op == OP_TICK)) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ev_hit && !stall) begin
					wr_en     = 1'b1;
					pend_load = 1'b1;
					out_load  = pend_valid_q;
					if (ev_exh) begin
						wr_data.retries = retry_limit_q;
						pend_kind_n     = KIND_EXHAUSTED;
					end else begin
						wr_data.timeout = timeout_dbl;
						wr_data.retries = ent_s1.retries - 4'd1;
						wr_data.stamp   = time_q;
					end
				end
				if (!issue_q && !vld_s1) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				case (op_q)
					OP_REQUEST: begin
						if (out_free) begin
							out_load   = 1'b1;
							out_id_n   = req_id_q;
							out_last_n = 1'b1;
							state_n    = ST_IDLE;
							if (found_q || free_found) begin
								wr_en      = 1'b1;
								wr_addr    = found_q ? found_slot_q : free_slot;
								wr_data    = '{id: req_id_q, stamp: time_q,
								               timeout: init_timeout_q, retries: retry_limit_q};
								valid_set  = 1'b1;
								out_kind_n = KIND_ACCEPTED;
							end else begin
								out_kind_n = KIND_FULL;
							end
						end
					end
					OP_RESPONSE: begin
						if (out_free) begin
							out_load   = 1'b1;
							out_id_n   = req_id_q;
							out_last_n = 1'b1;
							out_kind_n = found_q ? KIND_MATCHED : KIND_UNKNOWN;
							valid_clr  = found_q;
							state_n    = ST_IDLE;
						end
					end
					default: begin
						// Tick: release the held result as the last of the scan.
						if (!pend_valid_q) begin
							state_n = ST_IDLE;
						end else if (out_free) begin
							out_load    = 1'b1;
							out_tdone_n = 1'b1;
							out_last_n  = 1'b1;
							pend_clr    = 1'b1;
							state_n     = ST_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_REQUEST;
			time_q         <= '0;
			init_timeout_q <= INITIAL_TIMEOUT_RST;
			retry_limit_q  <= RETRY_LIMIT_RST;
			valid_q        <= '0;
			rd_addr_q      <= '0;
			issue_q        <= 1'b0;
			found_q        <= 1'b0;
			vld_s1         <= 1'b0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_INITIAL_TIMEOUT) begin
					init_timeout_q <= cfg_data;
				end else begin
					retry_limit_q <= cfg_data[3:0];
				end
			end
			if (in_acc) begin
				op_q      <= op;
				rd_addr_q <= '0;
				issue_q   <= 1'b1;
				found_q   <= 1'b0;
				if (op == OP_TICK) begin
					time_q <= time_q + 32'd1;
				end
			end else if (state_q == ST_SCAN && advance) begin
				vld_s1 <= issue_q && !ev_exh;
				if (issue_q) begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
				// Stop the walk after the last slot or at an exhausted entry.
				if ((rd_addr_q == LAST_SLOT) || ev_exh) begin
					issue_q <= 1'b0;
				end
				if (vld_s1 && valid_q[slot_s1] && ent_s1.id == req_id_q && !found_q) begin
					found_q <= 1'b1;
				end
			end
			if (valid_set) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (valid_clr) begin
				valid_q[found_slot_q] <= 1'b0;
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_id_q <= request_id;
		end
		if (state_q == ST_SCAN && advance) begin
			slot_s1 <= rd_addr_q;
			if (vld_s1 && valid_q[slot_s1] && ent_s1.id == req_id_q && !found_q) begin
				found_slot_q <= slot_s1;
			end
		end
		if (pend_load) begin
			pend_kind_q <= pend_kind_n;
			pend_id_q   <= ent_s1.id;
		end
		if (out_load) begin
			out_kind_q  <= out_kind_n;
			out_id_q    <= out_id_n;
			out_tdone_q <= out_tdone_n;
			out_last_q  <= out_last_n;
		end
	end

	`RRT_ASSERT_IMP(a_idle_clean, state_q == ST_IDLE, !vld_s1 && !pend_valid_q)
	`RRT_ASSERT_IMP(a_no_overwrite, out_load, out_free)
	`RRT_ASSERT_IMP(a_pend_tick_only, pend_valid_q, op_q == OP_TICK)
	`RRT_ASSERT_NXT(a_exh_stops, ev_exh && !stall, !issue_q && !vld_s1)

endmodule
